[rtl/utrb_pkg.sv]
// Shared definitions for the buffered serial-port FIFO block.
// Holds opcodes, default depths and the controller-to-datapath command struct.
package utrb_pkg;

  // Default FIFO depths.
  localparam int unsigned TxDepthDef = 64;
  localparam int unsigned RxDepthDef = 64;

  // Field widths.
  localparam int unsigned OpW   = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ErrW  = 4;
  localparam int unsigned FillW = 7;
  localparam int unsigned CntW  = 32;

  // Operation codes.
  localparam logic [OpW-1:0] OP_PUSH  = 2'd0;
  localparam logic [OpW-1:0] OP_POP   = 2'd1;
  localparam logic [OpW-1:0] OP_EVENT = 2'd2;
  localparam logic [OpW-1:0] OP_FLUSH = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the item and read both FIFO heads.
    logic execute;  // Apply the operation and register the result.
  } cmd_t;

endpackage

[rtl/utrb_ctrl.sv]
// Controller state machine for the buffered serial-port FIFO block.
// Depends on utrb_pkg for the command struct.
module utrb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output utrb_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next-state logic: accept, execute, then hold the result until taken.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshake and commands.
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.execute = (state_q == S_EXEC);

endmodule

[rtl/utrb_datapath.sv]
// Datapath of the buffered serial-port FIFO block: both ring memories,
// pointers, flags, counters and result registers. Depends on utrb_pkg.
module utrb_datapath #(
  parameter int unsigned TxDepth = utrb_pkg::TxDepthDef,
  parameter int unsigned RxDepth = utrb_pkg::RxDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  utrb_pkg::cmd_t               cmd_i,
  input  logic [utrb_pkg::OpW-1:0]     opcode_i,
  input  logic [utrb_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         tx_empty_flag_i,
  input  logic                         rx_ready_flag_i,
  input  logic [utrb_pkg::ErrW-1:0]    line_error_flags_i,
  output logic                         ok_o,
  output logic [utrb_pkg::ByteW-1:0]   read_byte_o,
  output logic                         send_valid_o,
  output logic [utrb_pkg::ByteW-1:0]   send_byte_o,
  output logic                         tx_irq_enable_o,
  output logic [utrb_pkg::FillW-1:0]   tx_fill_o,
  output logic [utrb_pkg::FillW-1:0]   rx_fill_o,
  output logic [utrb_pkg::CntW-1:0]    sent_total_o,
  output logic [utrb_pkg::CntW-1:0]    received_total_o,
  output logic [utrb_pkg::CntW-1:0]    error_total_o
);

  localparam int unsigned TxIw = (TxDepth > 1) ? $clog2(TxDepth) : 1;
  localparam int unsigned RxIw = (RxDepth > 1) ? $clog2(RxDepth) : 1;
  localparam int unsigned TxPw = $clog2(2 * TxDepth);
  localparam int unsigned RxPw = $clog2(2 * RxDepth);
  localparam logic [TxPw-1:0] TxD   = TxPw'(TxDepth);
  localparam logic [RxPw-1:0] RxD   = RxPw'(RxDepth);
  localparam logic [TxPw-1:0] TxTop = TxPw'(2 * TxDepth - 1);
  localparam logic [RxPw-1:0] RxTop = RxPw'(2 * RxDepth - 1);

  localparam int unsigned BW = utrb_pkg::ByteW;
  localparam int unsigned CW = utrb_pkg::CntW;

  // Ring memories.
  logic [BW-1:0] tx_mem [TxDepth];
  logic [BW-1:0] rx_mem [RxDepth];

  // Captured item and registered memory read data.
  logic [utrb_pkg::OpW-1:0]  op_q;
  logic [BW-1:0]             byte_q;
  logic                      txe_q, rxne_q;
  logic [utrb_pkg::ErrW-1:0] err_q;
  logic [BW-1:0]             tx_rd_q, rx_rd_q;

  // Architectural state.
  logic [TxPw-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [RxPw-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic            restart_q, restart_d, irq_q, irq_d;
  logic [CW-1:0]   sent_q, sent_d, recv_q, recv_d, err_cnt_q, err_cnt_d;

  // Result registers.
  logic          ok_q, ok_d, svalid_q, svalid_d;
  logic [BW-1:0] rbyte_q, rbyte_d, sbyte_q, sbyte_d;

  // Memory write controls.
  logic tx_we, rx_we;

  // Pointer helpers: pointers run modulo twice the depth.
  function automatic logic [TxPw-1:0] tx_next(input logic [TxPw-1:0] p);
    tx_next = (p == TxTop) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RxPw-1:0] rx_next(input logic [RxPw-1:0] p);
    rx_next = (p == RxTop) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TxIw-1:0] tx_idx(input logic [TxPw-1:0] p);
    logic [TxPw-1:0] r;
    r = (p >= TxD) ? p - TxD : p;
    tx_idx = r[TxIw-1:0];
  endfunction

  function automatic logic [RxIw-1:0] rx_idx(input logic [RxPw-1:0] p);
    logic [RxPw-1:0] r;
    r = (p >= RxD) ? p - RxD : p;
    rx_idx = r[RxIw-1:0];
  endfunction

  function automatic logic [TxPw-1:0] tx_level(input logic [TxPw-1:0] h,
                                               input logic [TxPw-1:0] t);
    tx_level = (h >= t) ? h - t : h + TxD + TxD - t;
  endfunction

  function automatic logic [RxPw-1:0] rx_level(input logic [RxPw-1:0] h,
                                               input logic [RxPw-1:0] t);
    rx_level = (h >= t) ? h - t : h + RxD + RxD - t;
  endfunction

  logic [TxPw-1:0] tx_lvl;
  logic [RxPw-1:0] rx_lvl;
  logic            tx_full, rx_full, rx_empty, tx_empty;

  assign tx_lvl   = tx_level(tx_head_q, tx_tail_q);
  assign rx_lvl   = rx_level(rx_head_q, rx_tail_q);
  assign tx_full  = (tx_lvl >= TxD);
  assign rx_full  = (rx_lvl >= RxD);
  assign rx_empty = (rx_lvl == '0);
  assign tx_empty = (tx_head_q == tx_tail_q);

  // Capture the item and read the oldest entry of each FIFO.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      byte_q  <= data_byte_i;
      txe_q   <= tx_empty_flag_i;
      rxne_q  <= rx_ready_flag_i;
      err_q   <= line_error_flags_i;
      tx_rd_q <= tx_mem[tx_idx(tx_tail_q)];
      rx_rd_q <= rx_mem[rx_idx(rx_tail_q)];
    end
  end

  // Memory writes happen during the execute cycle.
  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem[tx_idx(tx_head_q)] <= byte_q;
    if (rx_we) rx_mem[rx_idx(rx_head_q)] <= byte_q;
  end

  // Operation logic.
  always_comb begin
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    restart_d = restart_q;
    irq_d     = irq_q;
    sent_d    = sent_q;
    recv_d    = recv_q;
    err_cnt_d = err_cnt_q;
    ok_d      = 1'b1;
    rbyte_d   = '0;
    svalid_d  = 1'b0;
    sbyte_d   = '0;
    tx_we     = 1'b0;
    rx_we     = 1'b0;
    if (cmd_i.execute) begin
      unique case (op_q)
        utrb_pkg::OP_PUSH: begin
          if (!tx_full) begin
            tx_we     = 1'b1;
            tx_head_d = tx_next(tx_head_q);
            if (restart_q) begin
              restart_d = 1'b0;
              irq_d     = 1'b1;
            end
          end else begin
            ok_d = 1'b0;
          end
        end
        utrb_pkg::OP_POP: begin
          if (!rx_empty) begin
            rbyte_d   = rx_rd_q;
            rx_tail_d = rx_next(rx_tail_q);
          end else begin
            ok_d = 1'b0;
          end
        end
        utrb_pkg::OP_EVENT: begin
          if (txe_q) begin
            if (!tx_empty) begin
              sbyte_d   = tx_rd_q;
              svalid_d  = 1'b1;
              tx_tail_d = tx_next(tx_tail_q);
              restart_d = 1'b0;
              sent_d    = sent_q + 1'b1;
            end else begin
              restart_d = 1'b1;
              irq_d     = 1'b0;
            end
          end
          if (rxne_q && !rx_full) begin
            rx_we     = 1'b1;
            rx_head_d = rx_next(rx_head_q);
            recv_d    = recv_q + 1'b1;
          end
          if (err_q != '0) err_cnt_d = err_cnt_q + 1'b1;
        end
        utrb_pkg::OP_FLUSH: begin
          tx_head_d = '0;
          tx_tail_d = '0;
          rx_head_d = '0;
          rx_tail_d = '0;
          restart_d = 1'b1;
        end
        default: begin
          ok_d = 1'b1;
        end
      endcase
    end
  end

  // Control state: pointers, flags and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q <= '0;
      tx_tail_q <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      restart_q <= 1'b1;
      irq_q     <= 1'b0;
      sent_q    <= '0;
      recv_q    <= '0;
      err_cnt_q <= '0;
    end else if (cmd_i.execute) begin
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      restart_q <= restart_d;
      irq_q     <= irq_d;
      sent_q    <= sent_d;
      recv_q    <= recv_d;
      err_cnt_q <= err_cnt_d;
    end
  end

  // Result registers hold until the next execute cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      ok_q     <= ok_d;
      rbyte_q  <= rbyte_d;
      svalid_q <= svalid_d;
      sbyte_q  <= sbyte_d;
    end
  end

  // Outputs.
  assign ok_o             = ok_q;
  assign read_byte_o      = rbyte_q;
  assign send_valid_o     = svalid_q;
  assign send_byte_o      = sbyte_q;
  assign tx_irq_enable_o  = irq_q;
  assign tx_fill_o        = utrb_pkg::FillW'(tx_lvl);
  assign rx_fill_o        = utrb_pkg::FillW'(rx_lvl);
  assign sent_total_o     = sent_q;
  assign received_total_o = recv_q;
  assign error_total_o    = err_cnt_q;

endmodule

[rtl/uart_tx_rx_ring_buffers_core.sv]
// Top level of the buffered serial-port FIFO block: controller plus datapath.
// Depends on utrb_pkg, utrb_ctrl and utrb_datapath.
//
// Each transfer on the input channel is one operation (push a transmit
// byte, pop a received byte, a line-status event, or flush) and gives
// exactly one result transfer. The accept edge reads both FIFO memories
// into registers, the execute state applies the operation and writes
// memory and pointers, and the output state presents the result, which
// holds until taken; only then is a new item accepted. The registered
// read port of each ring memory is why the read comes before execute.
// FIFO levels, the interrupt enable and the wrapping counters describe
// the state after the operation. No clearing pass is needed after reset.
module uart_tx_rx_ring_buffers_core #(
  parameter int unsigned TxDepth = utrb_pkg::TxDepthDef,
  parameter int unsigned RxDepth = utrb_pkg::RxDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [utrb_pkg::OpW-1:0]   opcode_i,
  input  logic [utrb_pkg::ByteW-1:0] data_byte_i,
  input  logic                       tx_empty_flag_i,
  input  logic                       rx_ready_flag_i,
  input  logic [utrb_pkg::ErrW-1:0]  line_error_flags_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic [utrb_pkg::ByteW-1:0] read_byte_o,
  output logic                       send_valid_o,
  output logic [utrb_pkg::ByteW-1:0] send_byte_o,
  output logic                       tx_irq_enable_o,
  output logic [utrb_pkg::FillW-1:0] tx_fill_o,
  output logic [utrb_pkg::FillW-1:0] rx_fill_o,
  output logic [utrb_pkg::CntW-1:0]  sent_total_o,
  output logic [utrb_pkg::CntW-1:0]  received_total_o,
  output logic [utrb_pkg::CntW-1:0]  error_total_o
);

  utrb_pkg::cmd_t cmd;

  // Sequencing of accept, execute and result delivery.
  utrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // FIFO memories, pointers and counters.
  utrb_datapath #(
    .TxDepth (TxDepth),
    .RxDepth (RxDepth)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .opcode_i           (opcode_i),
    .data_byte_i        (data_byte_i),
    .tx_empty_flag_i    (tx_empty_flag_i),
    .rx_ready_flag_i    (rx_ready_flag_i),
    .line_error_flags_i (line_error_flags_i),
    .ok_o               (ok_o),
    .read_byte_o        (read_byte_o),
    .send_valid_o       (send_valid_o),
    .send_byte_o        (send_byte_o),
    .tx_irq_enable_o    (tx_irq_enable_o),
    .tx_fill_o          (tx_fill_o),
    .rx_fill_o          (rx_fill_o),
    .sent_total_o       (sent_total_o),
    .received_total_o   (received_total_o),
    .error_total_o      (error_total_o)
  );

endmodule

[test/tb_uart_tx_rx_ring_buffers_core.sv]
// Self-checking testbench for the buffered serial-port FIFO block.
// Needs utrb_pkg and uart_tx_rx_ring_buffers_core; a scoreboard class predicts each result.
`timescale 1ns / 100ps

module tb_uart_tx_rx_ring_buffers_core;

  localparam int unsigned TxDepth  = utrb_pkg::TxDepthDef;
  localparam int unsigned RxDepth  = utrb_pkg::RxDepthDef;
  localparam int unsigned PtrW     = $clog2(2 * TxDepth);
  localparam int unsigned NumItems = 700;

  typedef logic [utrb_pkg::OpW-1:0]   op_t;
  typedef logic [utrb_pkg::ByteW-1:0] byte_t;
  typedef logic [utrb_pkg::ErrW-1:0]  err_t;
  typedef logic [utrb_pkg::CntW-1:0]  word_t;

  // One result transfer, in port order.
  typedef struct packed {
    logic                         ok;
    logic [utrb_pkg::ByteW-1:0]   read_byte;
    logic                         send_valid;
    logic [utrb_pkg::ByteW-1:0]   send_byte;
    logic                         tx_irq_enable;
    logic [utrb_pkg::FillW-1:0]   tx_fill;
    logic [utrb_pkg::FillW-1:0]   rx_fill;
    logic [utrb_pkg::CntW-1:0]    sent_total;
    logic [utrb_pkg::CntW-1:0]    received_total;
    logic [utrb_pkg::CntW-1:0]    error_total;
  } reply_t;

  // Shadow copy of both rings and the counters, plus the replies still owed.
  class serial_fifo_scoreboard;
    byte_t            tx_mem [TxDepth];
    byte_t            rx_mem [RxDepth];
    logic [PtrW-1:0]  tx_wr, tx_rd, rx_wr, rx_rd;
    logic             restart_pending, irq_on;
    word_t            sent_cnt, recv_cnt, err_cnt;
    reply_t           expected_q[$];
    int unsigned      mismatches;

    function new();
      tx_wr = '0;
      tx_rd = '0;
      rx_wr = '0;
      rx_rd = '0;
      restart_pending = 1'b1;
      irq_on = 1'b0;
      sent_cnt = '0;
      recv_cnt = '0;
      err_cnt = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted operation to the shadow state and queue its reply.
    function void note_request(input op_t op, input byte_t data,
                               input logic txe, input logic rxne,
                               input err_t errs);
      reply_t          r;
      logic [PtrW-1:0] tx_lvl;
      logic [PtrW-1:0] rx_lvl;
      r = '0;
      r.ok = 1'b1;
      tx_lvl = tx_wr - tx_rd;
      rx_lvl = rx_wr - rx_rd;
      case (op)
        utrb_pkg::OP_PUSH: begin
          if (tx_lvl < TxDepth) begin
            tx_mem[tx_wr[PtrW-2:0]] = data;
            tx_wr = tx_wr + 1'b1;
            // An idle transmitter gets its interrupt enabled again.
            if (restart_pending) begin
              restart_pending = 1'b0;
              irq_on = 1'b1;
            end
          end else begin
            r.ok = 1'b0;
          end
        end
        utrb_pkg::OP_POP: begin
          if (rx_lvl != 0) begin
            r.read_byte = rx_mem[rx_rd[PtrW-2:0]];
            rx_rd = rx_rd + 1'b1;
          end else begin
            r.ok = 1'b0;
          end
        end
        utrb_pkg::OP_EVENT: begin
          // The transmit-empty flag is served whatever the enable holds.
          if (txe) begin
            if (tx_wr != tx_rd) begin
              r.send_valid = 1'b1;
              r.send_byte = tx_mem[tx_rd[PtrW-2:0]];
              tx_rd = tx_rd + 1'b1;
              restart_pending = 1'b0;
              sent_cnt = sent_cnt + 1'b1;
            end else begin
              restart_pending = 1'b1;
              irq_on = 1'b0;
            end
          end
          // A byte arriving at a full receive ring is dropped silently.
          if (rxne && rx_lvl < RxDepth) begin
            rx_mem[rx_wr[PtrW-2:0]] = data;
            rx_wr = rx_wr + 1'b1;
            recv_cnt = recv_cnt + 1'b1;
          end
          if (errs != '0) err_cnt = err_cnt + 1'b1;
        end
        default: begin
          // Flush empties both rings but keeps the enable and the counters.
          tx_wr = '0;
          tx_rd = '0;
          rx_wr = '0;
          rx_rd = '0;
          restart_pending = 1'b1;
        end
      endcase
      r.tx_irq_enable = irq_on;
      r.tx_fill = tx_wr - tx_rd;
      r.rx_fill = rx_wr - rx_rd;
      r.sent_total = sent_cnt;
      r.received_total = recv_cnt;
      r.error_total = err_cnt;
      expected_q.push_back(r);
    endfunction

    function void compare_field(input string name, input word_t want, input word_t got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    // Compare one result transfer against the oldest owed reply.
    function void check_reply(input reply_t got);
      reply_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result transfer with nothing owed", $time);
        return;
      end
      want = expected_q.pop_front();
      compare_field("ok", word_t'(want.ok), word_t'(got.ok));
      compare_field("read_byte", word_t'(want.read_byte), word_t'(got.read_byte));
      compare_field("send_valid", word_t'(want.send_valid), word_t'(got.send_valid));
      compare_field("send_byte", word_t'(want.send_byte), word_t'(got.send_byte));
      compare_field("tx_irq_enable", word_t'(want.tx_irq_enable),
                    word_t'(got.tx_irq_enable));
      compare_field("tx_fill", word_t'(want.tx_fill), word_t'(got.tx_fill));
      compare_field("rx_fill", word_t'(want.rx_fill), word_t'(got.rx_fill));
      compare_field("sent_total", want.sent_total, got.sent_total);
      compare_field("received_total", want.received_total, got.received_total);
      compare_field("error_total", want.error_total, got.error_total);
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [utrb_pkg::OpW-1:0]     opcode_i;
  logic [utrb_pkg::ByteW-1:0]   data_byte_i;
  logic                         tx_empty_flag_i;
  logic                         rx_ready_flag_i;
  logic [utrb_pkg::ErrW-1:0]    line_error_flags_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic                         ok_o;
  logic [utrb_pkg::ByteW-1:0]   read_byte_o;
  logic                         send_valid_o;
  logic [utrb_pkg::ByteW-1:0]   send_byte_o;
  logic                         tx_irq_enable_o;
  logic [utrb_pkg::FillW-1:0]   tx_fill_o;
  logic [utrb_pkg::FillW-1:0]   rx_fill_o;
  logic [utrb_pkg::CntW-1:0]    sent_total_o;
  logic [utrb_pkg::CntW-1:0]    received_total_o;
  logic [utrb_pkg::CntW-1:0]    error_total_o;

  serial_fifo_scoreboard sb = new();
  int unsigned items_sent;
  int unsigned results_seen;

  uart_tx_rx_ring_buffers_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .data_byte_i       (data_byte_i),
    .tx_empty_flag_i   (tx_empty_flag_i),
    .rx_ready_flag_i   (rx_ready_flag_i),
    .line_error_flags_i(line_error_flags_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .ok_o              (ok_o),
    .read_byte_o       (read_byte_o),
    .send_valid_o      (send_valid_o),
    .send_byte_o       (send_byte_o),
    .tx_irq_enable_o   (tx_irq_enable_o),
    .tx_fill_o         (tx_fill_o),
    .rx_fill_o         (rx_fill_o),
    .sent_total_o      (sent_total_o),
    .received_total_o  (received_total_o),
    .error_total_o     (error_total_o)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one operation, hold it until the transfer, then record it.
  task automatic send_item(input op_t op, input byte_t data,
                           input logic txe, input logic rxne, input err_t errs);
    int unsigned gap;
    if (!(items_sent >= 150 && items_sent < 300) && $urandom_range(0, 99) < 6) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    data_byte_i <= data;
    tx_empty_flag_i <= txe;
    rx_ready_flag_i <= rxne;
    line_error_flags_i <= errs;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, data, txe, rxne, errs);
    items_sent++;
  endtask

  // Stimulus: reset, directed cases, then segments of random traffic.
  initial begin : stimulus
    int unsigned seg;
    int unsigned kind;
    bit          paused;
    op_t         op;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i <= utrb_pkg::OP_PUSH;
    data_byte_i <= '0;
    tx_empty_flag_i <= 1'b0;
    rx_ready_flag_i <= 1'b0;
    line_error_flags_i <= '0;
    items_sent = 0;
    seg = 0;
    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pop from an empty receive ring, and transmit-empty with the enable still off.
    send_item(utrb_pkg::OP_POP, 8'hFF, 1'b1, 1'b1, 4'hF);
    send_item(utrb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b0, 4'h0);
    // Pushes into an idle transmitter, then hand bytes out.
    send_item(utrb_pkg::OP_PUSH, 8'h00, 1'b0, 1'b0, 4'h0);
    send_item(utrb_pkg::OP_PUSH, 8'hFF, 1'b1, 1'b1, 4'hF);
    send_item(utrb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b0, 4'h0);
    send_item(utrb_pkg::OP_EVENT, 8'hFF, 1'b1, 1'b1, 4'h1);
    // Transmit ring runs dry here, which drops the enable.
    send_item(utrb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b1, 4'h2);
    send_item(utrb_pkg::OP_EVENT, 8'h11, 1'b0, 1'b0, 4'h4);
    send_item(utrb_pkg::OP_EVENT, 8'h22, 1'b0, 1'b0, 4'h8);
    send_item(utrb_pkg::OP_EVENT, 8'hA5, 1'b0, 1'b1, 4'hF);
    send_item(utrb_pkg::OP_POP, 8'h00, 1'b0, 1'b0, 4'h0);
    send_item(utrb_pkg::OP_POP, 8'h00, 1'b0, 1'b0, 4'h0);
    send_item(utrb_pkg::OP_PUSH, 8'h5A, 1'b0, 1'b0, 4'h0);
    // Flush with data still in both rings.
    send_item(utrb_pkg::OP_FLUSH, 8'h00, 1'b0, 1'b0, 4'h0);
    send_item(utrb_pkg::OP_PUSH, 8'h3C, 1'b0, 1'b0, 4'h0);
    send_item(utrb_pkg::OP_EVENT, 8'h00, 1'b0, 1'b0, 4'h0);
    send_item(utrb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b0, 4'h0);
    send_item(utrb_pkg::OP_POP, 8'h00, 1'b1, 1'b1, 4'hF);
    send_item(utrb_pkg::OP_FLUSH, 8'hFF, 1'b1, 1'b1, 4'hF);

    while (items_sent < NumItems) begin
      // Once, halfway, let every owed result drain before going on.
      if (!paused && items_sent >= NumItems / 2) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk_i);
      end
      kind = (seg < 2) ? seg : $urandom_range(0, 3);
      seg++;
      case (kind)
        0: begin
          // Fill the transmit ring past full.
          repeat (TxDepth + 2)
            send_item(utrb_pkg::OP_PUSH, byte_t'($urandom), 1'($urandom), 1'($urandom),
                      err_t'($urandom));
        end
        1: begin
          // Fill the receive ring past full.
          repeat (RxDepth + 2)
            send_item(utrb_pkg::OP_EVENT, byte_t'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                      $urandom_range(0, 1) ? err_t'($urandom_range(1, 15)) : err_t'(0));
        end
        2: begin
          // Drain both rings.
          repeat (40)
            send_item($urandom_range(0, 1) ? utrb_pkg::OP_POP : utrb_pkg::OP_EVENT,
                      byte_t'($urandom), 1'b1, $urandom_range(0, 3) == 0,
                      err_t'($urandom));
        end
        default: begin
          // Mixed traffic with a rare flush.
          repeat (30) begin
            op = ($urandom_range(0, 15) == 0) ? utrb_pkg::OP_FLUSH
                                              : op_t'($urandom_range(0, 2));
            send_item(op, byte_t'($urandom), 1'($urandom), 1'($urandom), err_t'($urandom));
          end
        end
      endcase
    end

    // Wait for the last results, then keep the clock running for anything stray.
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: sample each transfer and stall at random.
  initial begin : result_side
    reply_t got;
    out_ready_i <= 1'b0;
    results_seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {ok_o, read_byte_o, send_valid_o, send_byte_o, tx_irq_enable_o, tx_fill_o,
               rx_fill_o, sent_total_o, received_total_o, error_total_o};
        sb.check_reply(got);
        results_seen++;
      end
      out_ready_i <= (results_seen >= 450 && results_seen < 600) ||
                     ($urandom_range(0, 99) >= 6);
    end
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[uart_tx_rx_ring_buffers_core.f]
rtl/utrb_pkg.sv
rtl/utrb_ctrl.sv
rtl/utrb_datapath.sv
rtl/uart_tx_rx_ring_buffers_core.sv
test/tb_uart_tx_rx_ring_buffers_core.sv
